// ----- sv/xst_pkg.sv -----
`timescale 1ns / 1ps

package xst_pkg;

  // Default size limits of the tokenizer.
  localparam int MaxTagBytesDef       = 64;
  localparam int MaxAttrsDef          = 16;
  localparam int MaxAttrNameBytesDef  = 64;
  localparam int MaxAttrValueBytesDef = 256;

  // Token queue between parser and output stage.
  localparam int QDepth = 4;
  localparam int QAw    = $clog2(QDepth);

  typedef enum logic [3:0] {
    KIND_TEXT     = 4'd0,
    KIND_TEXT_END = 4'd1,
    KIND_TAG      = 4'd2,
    KIND_ANAME    = 4'd3,
    KIND_AVALUE   = 4'd4,
    KIND_ADONE    = 4'd5,
    KIND_START    = 4'd6,
    KIND_END      = 4'd7,
    KIND_ERROR    = 4'd8
  } token_kind_e;

  typedef enum logic [2:0] {
    ERR_AFTER_LT   = 3'd0,
    ERR_IN_NAME    = 3'd1,
    ERR_IN_TAG     = 3'd2,
    ERR_ATTR_NAME  = 3'd3,
    ERR_NO_QUOTE   = 3'd4,
    ERR_NO_GT      = 3'd5
  } error_code_e;

  typedef struct packed {
    token_kind_e kind;
    logic [7:0]  value;
    logic [3:0]  attr_index;
    logic [4:0]  attr_count;
    logic        self_closing;
    logic        text_blank;
    error_code_e error_code;
    logic        last;
  } token_t;

  // Push request from the parser into the token queue.
  typedef struct packed {
    logic [1:0] count;
    token_t     tok0;
    token_t     tok1;
  } push_t;

endpackage

// ----- sv/xst_front.sv -----
`timescale 1ns / 1ps

module xst_front import xst_pkg::*; #(
  parameter int MAX_TAG_BYTES        = MaxTagBytesDef,
  parameter int MAX_ATTRS            = MaxAttrsDef,
  parameter int MAX_ATTR_NAME_BYTES  = MaxAttrNameBytesDef,
  parameter int MAX_ATTR_VALUE_BYTES = MaxAttrValueBytesDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       final_i,
  output push_t      push_o
);

  localparam int TagW = $clog2(MAX_TAG_BYTES);
  localparam int AttW = $clog2(MAX_ATTRS + 1);
  localparam int NamW = $clog2(MAX_ATTR_NAME_BYTES);
  localparam int ValW = $clog2(MAX_ATTR_VALUE_BYTES);

  localparam logic [TagW-1:0] TagLim = TagW'(MAX_TAG_BYTES - 1);
  localparam logic [AttW-1:0] AttLim = AttW'(MAX_ATTRS);
  localparam logic [NamW-1:0] NamLim = NamW'(MAX_ATTR_NAME_BYTES - 1);
  localparam logic [ValW-1:0] ValLim = ValW'(MAX_ATTR_VALUE_BYTES - 1);

  typedef enum logic [9:0] {
    MODE_TEXT      = 10'b00_0000_0001,
    MODE_TAG_START = 10'b00_0000_0010,
    MODE_TAG_NAME  = 10'b00_0000_0100,
    MODE_TAG_SPACE = 10'b00_0000_1000,
    MODE_ATTR_NAME = 10'b00_0001_0000,
    MODE_ATTR_EQ   = 10'b00_0010_0000,
    MODE_ATTR_VAL  = 10'b00_0100_0000,
    MODE_TAG_CLOSE = 10'b00_1000_0000,
    MODE_DECL      = 10'b01_0000_0000,
    MODE_HALT      = 10'b10_0000_0000
  } mode_e;

  mode_e           mode_q, mode_d;
  logic            end_tag_q, end_tag_d;
  logic            self_close_q, self_close_d;
  logic [TagW-1:0] tag_len_q, tag_len_d;
  logic [AttW-1:0] kept_q, kept_d;
  logic [NamW-1:0] name_len_q, name_len_d;
  logic [ValW-1:0] val_len_q, val_len_d;
  logic [7:0]      quote_q, quote_d;
  logic            pending_q, pending_d;
  logic            content_q, content_d;

  logic [AttW+4:0] kept_ext;
  logic [3:0]      idx4;
  logic [4:0]      cnt5;
  logic            keep;
  logic            ws, alpha, alnum;
  logic [1:0]      n;
  token_t          t0, t1;

  function automatic token_t mk_tok(token_kind_e k, logic [7:0] v, logic [3:0] idx,
                                    logic [4:0] cnt, logic sc, logic blank,
                                    error_code_e err);
    token_t t;
    t.kind         = k;
    t.value        = v;
    t.attr_index   = idx;
    t.attr_count   = cnt;
    t.self_closing = sc;
    t.text_blank   = blank;
    t.error_code   = err;
    t.last         = 1'b0;
    return t;
  endfunction

  // Character classes of the current byte.
  assign ws    = (byte_i == 8'h20) || (byte_i >= 8'h09 && byte_i <= 8'h0d);
  assign alpha = (byte_i >= "A" && byte_i <= "Z") || (byte_i >= "a" && byte_i <= "z");
  assign alnum = alpha || (byte_i >= "0" && byte_i <= "9");

  // Attribute counts carry only their low bits on the tokens.
  assign kept_ext = {5'b0, kept_q};
  assign idx4     = kept_ext[3:0];
  assign cnt5     = kept_ext[4:0];
  assign keep     = kept_q < AttLim;

  // Parser step: next state and up to two tokens for this byte.
  always_comb begin
    mode_d       = mode_q;
    end_tag_d    = end_tag_q;
    self_close_d = self_close_q;
    tag_len_d    = tag_len_q;
    kept_d       = kept_q;
    name_len_d   = name_len_q;
    val_len_d    = val_len_q;
    quote_d      = quote_q;
    pending_d    = pending_q;
    content_d    = content_q;
    n            = 2'd0;
    t0           = '0;
    t1           = '0;
    unique case (mode_q)
      MODE_TEXT: begin
        if (byte_i == "<") begin
          if (pending_q) begin
            t0 = mk_tok(KIND_TEXT_END, 8'd0, 4'd0, 5'd0, 1'b0, !content_q, ERR_AFTER_LT);
            n  = 2'd1;
          end
          pending_d    = 1'b0;
          content_d    = 1'b0;
          tag_len_d    = '0;
          end_tag_d    = 1'b0;
          self_close_d = 1'b0;
          kept_d       = '0;
          mode_d       = MODE_TAG_START;
        end else begin
          t0        = mk_tok(KIND_TEXT, byte_i, 4'd0, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT);
          n         = 2'd1;
          pending_d = 1'b1;
          content_d = content_q || !ws;
          if (final_i) begin
            t1 = mk_tok(KIND_TEXT_END, 8'd0, 4'd0, 5'd0, 1'b0, !(content_q || !ws),
                        ERR_AFTER_LT);
            n         = 2'd2;
            pending_d = 1'b0;
            content_d = 1'b0;
          end
        end
      end
      MODE_TAG_START: begin
        if (byte_i == "/") begin
          end_tag_d = 1'b1;
          mode_d    = MODE_TAG_NAME;
        end else if (byte_i == "!" || byte_i == "?") begin
          mode_d = MODE_DECL;
        end else if (alpha || byte_i == "_") begin
          t0        = mk_tok(KIND_TAG, byte_i, 4'd0, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT);
          n         = 2'd1;
          tag_len_d = TagW'(1);
          mode_d    = MODE_TAG_NAME;
        end else begin
          t0     = mk_tok(KIND_ERROR, 8'd0, 4'd0, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT);
          n      = 2'd1;
          mode_d = MODE_HALT;
        end
      end
      MODE_TAG_NAME: begin
        if (alnum || byte_i == "_" || byte_i == "-" || byte_i == ":" || byte_i == ".") begin
          if (tag_len_q < TagLim) begin
            t0        = mk_tok(KIND_TAG, byte_i, 4'd0, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT);
            n         = 2'd1;
            tag_len_d = tag_len_q + TagW'(1);
          end
        end else if (ws) begin
          mode_d = MODE_TAG_SPACE;
        end else if (byte_i == ">") begin
          t0 = end_tag_q ?
               mk_tok(KIND_END, 8'd0, 4'd0, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT) :
               mk_tok(KIND_START, 8'd0, 4'd0, cnt5, 1'b0, 1'b0, ERR_AFTER_LT);
          n      = 2'd1;
          mode_d = MODE_TEXT;
        end else if (byte_i == "/") begin
          self_close_d = 1'b1;
          mode_d       = MODE_TAG_CLOSE;
        end else begin
          t0     = mk_tok(KIND_ERROR, 8'd0, 4'd0, 5'd0, 1'b0, 1'b0, ERR_IN_NAME);
          n      = 2'd1;
          mode_d = MODE_HALT;
        end
      end
      MODE_TAG_SPACE: begin
        if (ws) begin
          mode_d = MODE_TAG_SPACE;
        end else if (byte_i == ">") begin
          t0 = end_tag_q ?
               mk_tok(KIND_END, 8'd0, 4'd0, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT) :
               mk_tok(KIND_START, 8'd0, 4'd0, cnt5, 1'b0, 1'b0, ERR_AFTER_LT);
          n      = 2'd1;
          mode_d = MODE_TEXT;
        end else if (byte_i == "/") begin
          self_close_d = 1'b1;
          mode_d       = MODE_TAG_CLOSE;
        end else if (alpha || byte_i == "_") begin
          name_len_d = '0;
          val_len_d  = '0;
          if (keep) begin
            t0         = mk_tok(KIND_ANAME, byte_i, idx4, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT);
            n          = 2'd1;
            name_len_d = NamW'(1);
          end
          mode_d = MODE_ATTR_NAME;
        end else begin
          t0     = mk_tok(KIND_ERROR, 8'd0, 4'd0, 5'd0, 1'b0, 1'b0, ERR_IN_TAG);
          n      = 2'd1;
          mode_d = MODE_HALT;
        end
      end
      MODE_ATTR_NAME: begin
        if (alnum || byte_i == "_" || byte_i == "-" || byte_i == ":") begin
          if (keep && name_len_q < NamLim) begin
            t0         = mk_tok(KIND_ANAME, byte_i, idx4, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT);
            n          = 2'd1;
            name_len_d = name_len_q + NamW'(1);
          end
        end else if (byte_i == "=") begin
          mode_d = MODE_ATTR_EQ;
        end else if (!ws) begin
          t0     = mk_tok(KIND_ERROR, 8'd0, 4'd0, 5'd0, 1'b0, 1'b0, ERR_ATTR_NAME);
          n      = 2'd1;
          mode_d = MODE_HALT;
        end
      end
      MODE_ATTR_EQ: begin
        if (byte_i == 8'h22 || byte_i == 8'h27) begin
          quote_d   = byte_i;
          val_len_d = '0;
          mode_d    = MODE_ATTR_VAL;
        end else if (!ws) begin
          t0     = mk_tok(KIND_ERROR, 8'd0, 4'd0, 5'd0, 1'b0, 1'b0, ERR_NO_QUOTE);
          n      = 2'd1;
          mode_d = MODE_HALT;
        end
      end
      MODE_ATTR_VAL: begin
        if (byte_i == quote_q) begin
          if (keep) begin
            t0     = mk_tok(KIND_ADONE, 8'd0, idx4, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT);
            n      = 2'd1;
            kept_d = kept_q + AttW'(1);
          end
          mode_d = MODE_TAG_SPACE;
        end else if (keep && val_len_q < ValLim) begin
          t0        = mk_tok(KIND_AVALUE, byte_i, idx4, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT);
          n         = 2'd1;
          val_len_d = val_len_q + ValW'(1);
        end
      end
      MODE_TAG_CLOSE: begin
        if (byte_i == ">") begin
          t0 = mk_tok(KIND_START, 8'd0, 4'd0, cnt5, self_close_q, 1'b0, ERR_AFTER_LT);
          n  = 2'd1;
          if (self_close_q && !end_tag_q) begin
            t1 = mk_tok(KIND_END, 8'd0, 4'd0, 5'd0, 1'b0, 1'b0, ERR_AFTER_LT);
            n  = 2'd2;
          end
          mode_d = MODE_TEXT;
        end else begin
          t0     = mk_tok(KIND_ERROR, 8'd0, 4'd0, 5'd0, 1'b0, 1'b0, ERR_NO_GT);
          n      = 2'd1;
          mode_d = MODE_HALT;
        end
      end
      MODE_DECL: begin
        if (byte_i == ">") begin
          mode_d = MODE_TEXT;
        end
      end
      default: begin
        mode_d = mode_q;
      end
    endcase
    // Mark the final token of this byte.
    if (n == 2'd1) begin
      t0.last = 1'b1;
    end
    if (n == 2'd2) begin
      t1.last = 1'b1;
    end
  end

  assign push_o.count = accept_i ? n : 2'd0;
  assign push_o.tok0  = t0;
  assign push_o.tok1  = t1;

  // Parser state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= MODE_TEXT;
      end_tag_q    <= 1'b0;
      self_close_q <= 1'b0;
      tag_len_q    <= '0;
      kept_q       <= '0;
      name_len_q   <= '0;
      val_len_q    <= '0;
      quote_q      <= 8'd0;
      pending_q    <= 1'b0;
      content_q    <= 1'b0;
    end else if (accept_i) begin
      mode_q       <= mode_d;
      end_tag_q    <= end_tag_d;
      self_close_q <= self_close_d;
      tag_len_q    <= tag_len_d;
      kept_q       <= kept_d;
      name_len_q   <= name_len_d;
      val_len_q    <= val_len_d;
      quote_q      <= quote_d;
      pending_q    <= pending_d;
      content_q    <= content_d;
    end
  end

  // Once halted, no byte gives a token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mode_q == MODE_HALT) |-> (push_o.count == 2'd0))
    else $error("token pushed while halted");

  // An error token always leaves the parser halted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && push_o.count != 2'd0 && push_o.tok0.kind == KIND_ERROR)
    |=> (mode_q == MODE_HALT))
    else $error("error token without halt");

  // The kept attribute count never passes its limit.
  assert property (@(posedge clk_i) disable iff (!rst_ni) kept_q <= AttLim)
    else $error("attribute count beyond limit");

endmodule

// ----- sv/xst_queue.sv -----
`timescale 1ns / 1ps

module xst_queue import xst_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  push_t  push_i,
  input  logic   pop_i,
  output token_t head_o,
  output logic   nonempty_o,
  output logic   space_o
);

  token_t         mem_q [QDepth];
  logic [QAw-1:0] wptr_q, rptr_q;
  logic [QAw:0]   count_q;
  logic [QAw-1:0] wptr1;

  assign wptr1      = wptr_q + QAw'(1);
  assign head_o     = mem_q[rptr_q];
  assign nonempty_o = count_q != '0;
  // Room for the two tokens a single byte can produce.
  assign space_o    = count_q <= (QAw+1)'(QDepth - 2);

  // Token storage; the second token lands behind the first.
  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wptr_q] <= push_i.tok0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wptr1] <= push_i.tok1;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + QAw'(push_i.count);
      rptr_q  <= rptr_q + QAw'(pop_i);
      count_q <= count_q + (QAw+1)'(push_i.count) - (QAw+1)'(pop_i);
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= (QAw+1)'(QDepth))
    else $error("token queue overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni) pop_i |-> nonempty_o)
    else $error("pop from empty token queue");

endmodule

// ----- sv/xst_back.sv -----
`timescale 1ns / 1ps

module xst_back import xst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  token_t      head_i,
  input  logic        nonempty_i,
  output logic        pop_o,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  token_t out_q;
  logic   valid_q;

  // Load a new token when the register is empty or being drained.
  assign pop_o = nonempty_i && (!valid_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!valid_q || m_axis_tready) begin
      valid_q <= nonempty_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      out_q <= head_i;
    end
  end

  // Field packing of the result channel.
  assign m_axis_tvalid = valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {2'b00, out_q.error_code, out_q.text_blank, out_q.self_closing,
                          out_q.attr_count, out_q.attr_index, out_q.value};

endmodule

// ----- sv/xml_sax_tokenizer.sv -----
`timescale 1ns / 1ps
// Each token is registered in the token queue and then in the output register. Input takes
// one byte per cycle while the token queue has room; a byte that yields two tokens needs
// two result transfers; the channel drains the queue one entry per cycle while it is ready.
// Input is held off while the four-entry token queue lacks room for two tokens.
// Reset (rst_ni low, asynchronous) returns the parser to text mode and empties the queue.
module xml_sax_tokenizer import xst_pkg::*; #(
  parameter int MAX_TAG_BYTES        = MaxTagBytesDef,
  parameter int MAX_ATTRS            = MaxAttrsDef,
  parameter int MAX_ATTR_NAME_BYTES  = MaxAttrNameBytesDef,
  parameter int MAX_ATTR_VALUE_BYTES = MaxAttrValueBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,  // [7:0] data_byte
  input  logic        s_axis_tlast,  // final_flag
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] value_byte, [11:8] attr_index, [16:12] attr_count, [17] self_closing,
  // [18] text_blank, [21:19] error_code, [23:22] zero
  output logic [23:0] m_axis_tdata,
  output logic [3:0]  m_axis_tuser,  // [3:0] token_kind
  output logic        m_axis_tlast   // last
);

  push_t  push;
  token_t head;
  logic   nonempty, space, pop, accept;

  assign s_axis_tready = space;
  assign accept        = s_axis_tvalid && space;

  xst_front #(
    .MAX_TAG_BYTES       (MAX_TAG_BYTES),
    .MAX_ATTRS           (MAX_ATTRS),
    .MAX_ATTR_NAME_BYTES (MAX_ATTR_NAME_BYTES),
    .MAX_ATTR_VALUE_BYTES(MAX_ATTR_VALUE_BYTES)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (s_axis_tdata),
    .final_i (s_axis_tlast),
    .push_o  (push)
  );

  xst_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (pop),
    .head_o    (head),
    .nonempty_o(nonempty),
    .space_o   (space)
  );

  xst_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .nonempty_i   (nonempty),
    .pop_o        (pop),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

endmodule

// ----- tb/xml_sax_tokenizer_tb.sv -----
`timescale 1ns / 1ps

module xml_sax_tokenizer_tb;
  import xst_pkg::*;

  // Allows for thousands of bytes, each with the longest gaps and stalls.
  localparam int CycleLimit = 800000;

  // Bytes with a meaning to the parser.
  localparam logic [7:0] LT     = 8'h3C;
  localparam logic [7:0] GT     = 8'h3E;
  localparam logic [7:0] SLASH  = 8'h2F;
  localparam logic [7:0] BANG   = 8'h21;
  localparam logic [7:0] QMARK  = 8'h3F;
  localparam logic [7:0] EQ     = 8'h3D;
  localparam logic [7:0] DQUOTE = 8'h22;
  localparam logic [7:0] SQUOTE = 8'h27;
  localparam logic [7:0] USCORE = 8'h5F;
  localparam logic [7:0] DASH   = 8'h2D;
  localparam logic [7:0] COLON  = 8'h3A;
  localparam logic [7:0] DOT    = 8'h2E;
  localparam logic [7:0] SPACE  = 8'h20;

  typedef enum logic [3:0] {
    P_TEXT, P_TAG_START, P_TAG_NAME, P_TAG_SPACE, P_ATTR_NAME, P_ATTR_EQ,
    P_ATTR_VALUE, P_TAG_CLOSE, P_DECL, P_HALT
  } parse_mode_e;

  typedef struct {
    logic [7:0] data;
    logic       final_byte;
  } stream_byte_t;

  logic        clk_i = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic [7:0]  in_data = 8'd0;
  logic        in_last = 1'b0;
  logic        s_ready;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [23:0] out_data;
  logic [3:0]  out_kind;
  logic        out_last;

  xml_sax_tokenizer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_n),
    .s_axis_tvalid (in_valid),
    .s_axis_tready (s_ready),
    .s_axis_tdata  (in_data),
    .s_axis_tlast  (in_last),
    .m_axis_tvalid (out_valid),
    .m_axis_tready (out_ready),
    .m_axis_tdata  (out_data),
    .m_axis_tuser  (out_kind),
    .m_axis_tlast  (out_last)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Parser state mirrored by the tokenizer model below.
  parse_mode_e p_mode = P_TEXT;
  logic        p_end_tag = 1'b0;
  logic        p_self_close = 1'b0;
  int          p_tag_len = 0;
  int          p_kept = 0;
  int          p_name_len = 0;
  int          p_value_len = 0;
  logic [7:0]  p_quote = 8'd0;
  logic        p_text_pending = 1'b0;
  logic        p_text_content = 1'b0;

  token_t       expected_tokens[$];
  stream_byte_t byte_q[$];
  int           live_bytes = 0;
  int           mismatches = 0;

  function automatic bit coin(int n);
    return $urandom_range(0, n - 1) == 0;
  endfunction

  function automatic bit is_blank(logic [7:0] c);
    return c == SPACE || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic bit is_alnum(logic [7:0] c);
    return is_letter(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic token_t mk_token(token_kind_e kind, logic [7:0] value = 8'd0,
                                      int idx = 0, int cnt = 0, logic sc = 1'b0,
                                      logic blank = 1'b0,
                                      error_code_e err = ERR_AFTER_LT);
    token_t t;
    t.kind         = kind;
    t.value        = value;
    t.attr_index   = idx[3:0];
    t.attr_count   = cnt[4:0];
    t.self_closing = sc;
    t.text_blank   = blank;
    t.error_code   = err;
    t.last         = 1'b0;
    return t;
  endfunction

  // Advances the tokenizer model by one accepted byte and queues its tokens.
  function automatic void tokenize_byte(logic [7:0] c, logic fin);
    token_t toks[$];
    bit     keep;
    keep = p_kept < MaxAttrsDef;
    case (p_mode)
      P_TEXT: begin
        if (c == LT) begin
          if (p_text_pending) begin
            toks.push_back(mk_token(KIND_TEXT_END, 8'd0, 0, 0, 1'b0, !p_text_content));
          end
          p_text_pending = 1'b0;
          p_text_content = 1'b0;
          p_tag_len      = 0;
          p_end_tag      = 1'b0;
          p_self_close   = 1'b0;
          p_kept         = 0;
          p_mode         = P_TAG_START;
        end else begin
          toks.push_back(mk_token(KIND_TEXT, c));
          p_text_pending = 1'b1;
          if (!is_blank(c)) p_text_content = 1'b1;
          // The final byte flushes the run.
          if (fin) begin
            toks.push_back(mk_token(KIND_TEXT_END, 8'd0, 0, 0, 1'b0, !p_text_content));
            p_text_pending = 1'b0;
            p_text_content = 1'b0;
          end
        end
      end
      P_TAG_START: begin
        if (c == SLASH) begin
          p_end_tag = 1'b1;
          p_mode    = P_TAG_NAME;
        end else if (c == BANG || c == QMARK) begin
          p_mode = P_DECL;
        end else if (is_letter(c) || c == USCORE) begin
          toks.push_back(mk_token(KIND_TAG, c));
          p_tag_len = 1;
          p_mode    = P_TAG_NAME;
        end else begin
          toks.push_back(mk_token(KIND_ERROR, 8'd0, 0, 0, 1'b0, 1'b0, ERR_AFTER_LT));
          p_mode = P_HALT;
        end
      end
      P_TAG_NAME: begin
        if (is_alnum(c) || c == USCORE || c == DASH || c == COLON || c == DOT) begin
          if (p_tag_len < MaxTagBytesDef - 1) begin
            toks.push_back(mk_token(KIND_TAG, c));
            p_tag_len++;
          end
        end else if (is_blank(c)) begin
          p_mode = P_TAG_SPACE;
        end else if (c == GT) begin
          toks.push_back(p_end_tag ? mk_token(KIND_END) : mk_token(KIND_START, 8'd0, 0, p_kept));
          p_mode = P_TEXT;
        end else if (c == SLASH) begin
          p_self_close = 1'b1;
          p_mode       = P_TAG_CLOSE;
        end else begin
          toks.push_back(mk_token(KIND_ERROR, 8'd0, 0, 0, 1'b0, 1'b0, ERR_IN_NAME));
          p_mode = P_HALT;
        end
      end
      P_TAG_SPACE: begin
        if (is_blank(c)) begin
          // Nothing to do between attributes.
        end else if (c == GT) begin
          toks.push_back(p_end_tag ? mk_token(KIND_END) : mk_token(KIND_START, 8'd0, 0, p_kept));
          p_mode = P_TEXT;
        end else if (c == SLASH) begin
          p_self_close = 1'b1;
          p_mode       = P_TAG_CLOSE;
        end else if (is_letter(c) || c == USCORE) begin
          p_name_len  = 0;
          p_value_len = 0;
          if (keep) begin
            toks.push_back(mk_token(KIND_ANAME, c, p_kept));
            p_name_len = 1;
          end
          p_mode = P_ATTR_NAME;
        end else begin
          toks.push_back(mk_token(KIND_ERROR, 8'd0, 0, 0, 1'b0, 1'b0, ERR_IN_TAG));
          p_mode = P_HALT;
        end
      end
      P_ATTR_NAME: begin
        if (is_alnum(c) || c == USCORE || c == DASH || c == COLON) begin
          if (keep && p_name_len < MaxAttrNameBytesDef - 1) begin
            toks.push_back(mk_token(KIND_ANAME, c, p_kept));
            p_name_len++;
          end
        end else if (c == EQ) begin
          p_mode = P_ATTR_EQ;
        end else if (!is_blank(c)) begin
          // Blanks inside a name are skipped, anything else is fatal.
          toks.push_back(mk_token(KIND_ERROR, 8'd0, 0, 0, 1'b0, 1'b0, ERR_ATTR_NAME));
          p_mode = P_HALT;
        end
      end
      P_ATTR_EQ: begin
        if (c == DQUOTE || c == SQUOTE) begin
          p_quote     = c;
          p_value_len = 0;
          p_mode      = P_ATTR_VALUE;
        end else if (!is_blank(c)) begin
          toks.push_back(mk_token(KIND_ERROR, 8'd0, 0, 0, 1'b0, 1'b0, ERR_NO_QUOTE));
          p_mode = P_HALT;
        end
      end
      P_ATTR_VALUE: begin
        if (c == p_quote) begin
          if (keep) begin
            toks.push_back(mk_token(KIND_ADONE, 8'd0, p_kept));
            p_kept++;
          end
          p_mode = P_TAG_SPACE;
        end else if (keep && p_value_len < MaxAttrValueBytesDef - 1) begin
          toks.push_back(mk_token(KIND_AVALUE, c, p_kept));
          p_value_len++;
        end
      end
      P_TAG_CLOSE: begin
        if (c == GT) begin
          toks.push_back(mk_token(KIND_START, 8'd0, 0, p_kept, p_self_close));
          if (p_self_close && !p_end_tag) toks.push_back(mk_token(KIND_END));
          p_mode = P_TEXT;
        end else begin
          toks.push_back(mk_token(KIND_ERROR, 8'd0, 0, 0, 1'b0, 1'b0, ERR_NO_GT));
          p_mode = P_HALT;
        end
      end
      P_DECL: begin
        if (c == GT) p_mode = P_TEXT;
      end
      default: begin
        // Halted until reset.
      end
    endcase
    if (toks.size() > 0) toks[toks.size() - 1].last = 1'b1;
    foreach (toks[i]) expected_tokens.push_back(toks[i]);
  endfunction

  // Stimulus builders; they append bytes to the pending queue.
  function automatic void push_byte(logic [7:0] c, logic fin, bit ignored);
    stream_byte_t b;
    b.data       = c;
    b.final_byte = fin;
    byte_q.push_back(b);
    if (!ignored) live_bytes++;
  endfunction

  function automatic void push_r(logic [7:0] c);
    push_byte(c, coin(16), 1'b0);
  endfunction

  function automatic void push_str(string s);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], 1'b0, 1'b0);
  endfunction

  function automatic logic [7:0] blank_char();
    logic [7:0] blanks [6];
    blanks = '{SPACE, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D};
    return blanks[$urandom_range(0, 5)];
  endfunction

  function automatic logic [7:0] letter();
    logic [7:0] c;
    c = 8'h61 + 8'($urandom_range(0, 25));
    if (coin(2)) c = c - 8'h20;
    return c;
  endfunction

  function automatic logic [7:0] name_char(bit for_tag);
    logic [7:0] c;
    case ($urandom_range(0, 9))
      6: c = 8'h30 + 8'($urandom_range(0, 9));
      7: c = USCORE;
      8: c = coin(2) ? DASH : COLON;
      9: c = for_tag ? DOT : DASH;
      default: c = letter();
    endcase
    return c;
  endfunction

  function automatic int pick_len(int normal_max, int big);
    return coin(40) ? big : $urandom_range(1, normal_max);
  endfunction

  // Attribute names may carry blanks after the first byte.
  function automatic void gen_name(bit for_tag, int len);
    push_r(coin(5) ? USCORE : letter());
    for (int i = 1; i < len; i++) begin
      if (!for_tag && coin(8)) push_r(blank_char());
      push_r(name_char(for_tag));
    end
  endfunction

  function automatic void gen_text(int len, bit blank_only);
    logic [7:0] c;
    for (int i = 0; i < len; i++) begin
      if (blank_only || coin(3)) begin
        c = blank_char();
      end else begin
        do c = 8'($urandom_range(0, 255)); while (c == LT);
      end
      push_r(c);
    end
  endfunction

  function automatic void gen_attr(int name_len, int value_len);
    logic [7:0] q;
    logic [7:0] c;
    push_r(blank_char());
    if (coin(4)) push_r(blank_char());
    gen_name(1'b0, name_len);
    if (coin(4)) push_r(blank_char());
    push_r(EQ);
    if (coin(4)) push_r(blank_char());
    q = coin(2) ? DQUOTE : SQUOTE;
    push_r(q);
    for (int i = 0; i < value_len; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == q);
      push_r(c);
    end
    push_r(q);
  endfunction

  // A zero name length is only legal in an end tag.
  function automatic void gen_tag(bit closing, bit self_close, int name_len, int n_attrs);
    push_r(LT);
    if (closing) push_r(SLASH);
    if (name_len > 0) gen_name(1'b1, name_len);
    for (int i = 0; i < n_attrs; i++) begin
      gen_attr(pick_len(6, 70), coin(6) ? 0 : pick_len(8, 260));
    end
    if (coin(3)) push_r(blank_char());
    if (self_close) push_r(SLASH);
    push_r(GT);
  endfunction

  function automatic void gen_decl();
    logic [7:0] c;
    int         len;
    push_r(LT);
    push_r(coin(2) ? BANG : QMARK);
    len = $urandom_range(0, 10);
    for (int i = 0; i < len; i++) begin
      do c = 8'($urandom_range(0, 255)); while (c == GT);
      push_byte(c, coin(16), 1'b1);
    end
    push_r(GT);
  endfunction

  // One syntax error chosen at random, then bytes that the halted parser swallows.
  function automatic void gen_error();
    logic [7:0]  bad [5];
    error_code_e code;
    code = error_code_e'($urandom_range(0, 5));
    case (code)
      ERR_AFTER_LT: begin
        push_str("<");
        bad = '{8'h31, SPACE, GT, EQ, 8'hE9};
      end
      ERR_IN_NAME: begin
        push_str("<ab");
        bad = '{EQ, DQUOTE, LT, BANG, 8'h80};
      end
      ERR_IN_TAG: begin
        push_str("<ab ");
        bad = '{EQ, 8'h31, LT, DASH, 8'hFF};
      end
      ERR_ATTR_NAME: begin
        push_str("<ab c");
        bad = '{DOT, GT, SLASH, DQUOTE, 8'h00};
      end
      ERR_NO_QUOTE: begin
        push_str("<ab c =");
        bad = '{8'h78, GT, EQ, LT, 8'h7F};
      end
      default: begin
        push_str("<ab/");
        bad = '{8'h78, SLASH, SPACE, LT, 8'h01};
      end
    endcase
    push_byte(bad[$urandom_range(0, 4)], coin(2), 1'b0);
    push_str("<x>text</x>");
    for (int i = 0; i < 8; i++) push_byte(8'($urandom_range(0, 255)), coin(2), 1'b1);
  endfunction

  // Driver: bursts of requests separated by random gaps.
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    stream_byte_t nxt;
    if (rst_n) begin
      if (in_valid && s_ready) tokenize_byte(in_data, in_last);
      if (!in_valid || s_ready) begin
        if (gap_left > 0 || byte_q.size() == 0) begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end else begin
          nxt = byte_q.pop_front();
          in_valid <= 1'b1;
          in_data  <= nxt.data;
          in_last  <= nxt.final_byte;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = coin(3) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  function automatic void check_field(string field, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endfunction

  // Monitor: ready follows a 16-bit mask that is redrawn each time the phase counter wraps.
  logic [15:0] ready_mask = 16'hFFFF;
  int          ready_phase = 0;

  always @(posedge clk_i) begin
    token_t want;
    if (ready_phase == 63) ready_mask <= coin(3) ? 16'hFFFF : 16'($urandom);
    ready_phase <= (ready_phase + 1) % 64;
    out_ready   <= ready_mask[ready_phase % 16];
    if (rst_n && out_valid && out_ready) begin
      if (expected_tokens.size() == 0) begin
        $error("token_kind: expected none, got %0d", out_kind);
        mismatches++;
      end else begin
        want = expected_tokens.pop_front();
        check_field("token_kind", want.kind, out_kind);
        check_field("value_byte", want.value, out_data[7:0]);
        check_field("attr_index", want.attr_index, out_data[11:8]);
        check_field("attr_count", want.attr_count, out_data[16:12]);
        check_field("self_closing", want.self_closing, out_data[17]);
        check_field("text_blank", want.text_blank, out_data[18]);
        check_field("error_code", want.error_code, out_data[21:19]);
        check_field("tdata_pad", 0, out_data[23:22]);
        check_field("last", want.last, out_last);
      end
    end
  end

  int cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    int random_goal;

    // Declarations, attributes of both quote styles, a blank text run.
    push_str("<?xml version=\"1.0\"?><!-- note -->");
    push_str("<root a=\"1\" b='x'> \t\n");
    push_byte(8'h0B, 1'b0, 1'b0);
    push_byte(8'h0C, 1'b0, 1'b0);
    push_byte(8'h0D, 1'b0, 1'b0);
    // Odd name bytes, a blank inside an attribute name, text ended by the final byte.
    push_str("<_n-1:x.y q z = 'v'>hi");
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b1, 1'b0);
    // Self-closing forms, an empty end tag and an end tag with a trailing blank.
    push_str("</_n-1:x.y><e/><e x=\"");
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_str("\" /></a/></></b >");
    // Truncated tag name, attribute name and value, plus dropped attributes.
    push_byte(LT, 1'b0, 1'b0);
    gen_name(1'b1, 70);
    gen_attr(70, 260);
    for (int i = 0; i < 18; i++) gen_attr(2, 2);
    push_byte(GT, 1'b0, 1'b0);
    push_str("end");
    push_byte(8'h2E, 1'b1, 1'b0);

    // Random documents: mostly well-formed markup with random content.
    random_goal = live_bytes + 400;
    while (live_bytes < random_goal) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gen_text(pick_len(12, 40), coin(4));
        3, 4, 5: gen_tag(1'b0, 1'b0, pick_len(6, 70),
                         coin(25) ? $urandom_range(16, 19) : $urandom_range(0, 3));
        6, 7: gen_tag(1'b1, 1'b0, coin(8) ? 0 : pick_len(6, 70), coin(8) ? 1 : 0);
        8: gen_tag(coin(4), 1'b1, pick_len(6, 70), $urandom_range(0, 2));
        default: gen_decl();
      endcase
    end
    gen_error();

    repeat (4) @(posedge clk_i);
    rst_n <= 1'b1;

    while (byte_q.size() != 0 || in_valid || expected_tokens.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (10) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
